// ===== src/analog_command_scaler_core_assert.svh =====
// Assertion macros shared by the checker of the analog command scaler
`ifndef ANALOG_COMMAND_SCALER_CORE_ASSERT_SVH
`define ANALOG_COMMAND_SCALER_CORE_ASSERT_SVH

// Property that must hold at every clock edge out of reset
`define ACS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen out of reset
`define ACS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== src/acs_pkg.sv =====
// Types, constants and scaling helpers of the analog command scaler
`default_nettype none
package acs_pkg;

	localparam int NumPorts = 3;
	localparam int SampleW  = 10;
	localparam int CmdW     = 9;
	localparam int AdjW     = 8;
	localparam int RoleW    = 3;
	localparam int RegIdxW  = 3;
	localparam int PaddrW   = 5;
	localparam int PdataW   = 32;

	localparam logic [RoleW-1:0] RoleCur15 = 3'd1;
	localparam logic [RoleW-1:0] RoleCur12 = 3'd2;
	localparam logic [RoleW-1:0] RoleCur10 = 3'd3;
	localparam logic [RoleW-1:0] RoleVol15 = 3'd4;
	localparam logic [RoleW-1:0] RoleVol12 = 3'd5;
	localparam logic [RoleW-1:0] RoleVol10 = 3'd6;

	localparam logic [RegIdxW-1:0] RegLink    = 3'd0;
	localparam logic [RegIdxW-1:0] RegUnified = 3'd1;
	localparam logic [RegIdxW-1:0] RegRole0   = 3'd2;
	localparam logic [RegIdxW-1:0] RegRole1   = 3'd3;
	localparam logic [RegIdxW-1:0] RegRole2   = 3'd4;

	localparam logic [8:0]  SampleLimit = 9'd500;
	localparam logic [8:0]  AdjLimit    = 9'd446;
	localparam logic [8:0]  AdjMid      = 9'd223;
	localparam logic [15:0] AdjGain     = 16'd240;
	localparam logic [15:0] AdjBias     = 16'd223;
	localparam logic [10:0] CurOffset   = 11'd30;
	localparam logic [10:0] CurMax      = 11'd350;
	localparam logic [10:0] VolOffset   = 11'd49;
	localparam logic [10:0] VolMin      = 11'd50;
	localparam logic [10:0] VolMax      = 11'd400;
	localparam logic [7:0]  AdjMax      = 8'd120;
	// floor(x/100) = (x*5243)>>19 for every even x up to 57000 and every x below 43690
	localparam logic [12:0] VolRecip    = 13'd5243;
	localparam int          VolShift    = 19;
	// floor(x/446) = (x*150469)>>26 for x below 2^16
	localparam logic [17:0] AdjRecip    = 18'd150469;
	localparam int          AdjShift    = 26;

	typedef struct packed {
		logic                           connected;
		logic                           unified;
		logic [NumPorts-1:0][RoleW-1:0] role;
	} cfg_t;

	typedef struct packed {
		logic [CmdW-1:0]        cur;
		logic [CmdW-1:0]        vol;
		logic signed [AdjW-1:0] adj;
	} lane_res_t;

	function automatic logic is_cur_role(input logic [RoleW-1:0] role);
		return (role == RoleCur15) || (role == RoleCur12) || (role == RoleCur10);
	endfunction

	function automatic logic is_vol_role(input logic [RoleW-1:0] role);
		return (role == RoleVol15) || (role == RoleVol12) || (role == RoleVol10);
	endfunction

	function automatic logic [6:0] cur_mul(input logic [RoleW-1:0] role);
		logic [6:0] k;
		case (role)
			RoleCur15: k = 7'd44;
			RoleCur12: k = 7'd55;
			default:   k = 7'd66;
		endcase
		return k;
	endfunction

	function automatic logic [6:0] vol_mul(input logic [RoleW-1:0] role);
		logic [6:0] m;
		case (role)
			RoleVol15: m = 7'd75;
			RoleVol12: m = 7'd92;
			default:   m = 7'd114;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== src/acs_regs.sv =====
// APB configuration registers of the analog command scaler
`default_nettype none
module acs_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [acs_pkg::PaddrW-1:0] paddr,
	input  wire logic [acs_pkg::PdataW-1:0] pwdata,
	output logic      [acs_pkg::PdataW-1:0] prdata,
	output logic                            pready,
	output acs_pkg::cfg_t                   cfg
);
	import acs_pkg::*;

	cfg_t               cfg_q;
	logic               wr_en;
	logic [RegIdxW-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[PaddrW-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				RegLink:    cfg_q.connected <= pwdata[0];
				RegUnified: cfg_q.unified   <= pwdata[0];
				RegRole0:   cfg_q.role[0]   <= pwdata[RoleW-1:0];
				RegRole1:   cfg_q.role[1]   <= pwdata[RoleW-1:0];
				RegRole2:   cfg_q.role[2]   <= pwdata[RoleW-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			RegLink:    prdata[0]         = cfg_q.connected;
			RegUnified: prdata[0]         = cfg_q.unified;
			RegRole0:   prdata[RoleW-1:0] = cfg_q.role[0];
			RegRole1:   prdata[RoleW-1:0] = cfg_q.role[1];
			RegRole2:   prdata[RoleW-1:0] = cfg_q.role[2];
			default:    prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/acs_lane.sv =====
// One scaling lane: current, voltage and adjust for a single port sample
`default_nettype none
module acs_lane (
	input  wire logic                         clk,
	input  wire logic                         load_s1,
	input  wire logic                         load_s2,
	input  wire logic [acs_pkg::SampleW-1:0]  sample,
	input  wire logic [acs_pkg::RoleW-1:0]    role,
	output acs_pkg::lane_res_t                res
);
	import acs_pkg::*;

	logic [8:0]  v_lim;
	logic [8:0]  a_lim;
	logic        a_neg;
	logic [7:0]  a_mag;
	logic [15:0] cur_prod;
	logic [15:0] vol_prod;
	logic [15:0] adj_num;

	logic [15:0] cur_prod_s1;
	logic [15:0] vol_prod_s1;
	logic [15:0] adj_num_s1;
	logic        adj_neg_s1;

	logic [10:0] cur_sum;
	logic [28:0] vol_full;
	logic [10:0] vol_sum;
	logic [33:0] adj_full;
	logic [7:0]  adj_mag;
	lane_res_t   res_next;
	lane_res_t   res_s2;

	always_comb begin
		v_lim    = (sample > 10'(SampleLimit)) ? SampleLimit : sample[8:0];
		a_lim    = (sample > 10'(AdjLimit)) ? AdjLimit : sample[8:0];
		a_neg    = a_lim < AdjMid;
		a_mag    = a_neg ? 8'(AdjMid - a_lim) : 8'(a_lim - AdjMid);
		cur_prod = 16'(v_lim) * 16'(cur_mul(role));
		vol_prod = 16'(v_lim) * 16'(vol_mul(role));
		adj_num  = 16'(a_mag) * AdjGain + AdjBias;
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cur_prod_s1 <= cur_prod;
			vol_prod_s1 <= vol_prod;
			adj_num_s1  <= adj_num;
			adj_neg_s1  <= a_neg;
		end
	end

	always_comb begin
		cur_sum  = 11'(cur_prod_s1[15:6]) + CurOffset;
		vol_full = 29'(vol_prod_s1) * 29'(VolRecip);
		vol_sum  = 11'(vol_full[VolShift +: 10]) + VolOffset;
		adj_full = 34'(adj_num_s1) * 34'(AdjRecip);
		adj_mag  = adj_full[AdjShift +: 8];
		if (adj_mag > AdjMax) begin
			adj_mag = AdjMax;
		end

		res_next.cur = (cur_sum > CurMax) ? CmdW'(CurMax) : CmdW'(cur_sum);
		if (vol_sum > VolMax) begin
			res_next.vol = CmdW'(VolMax);
		end else if (vol_sum < VolMin) begin
			res_next.vol = CmdW'(VolMin);
		end else begin
			res_next.vol = CmdW'(vol_sum);
		end
		res_next.adj = adj_neg_s1 ? AdjW'(8'd0 - adj_mag) : AdjW'(adj_mag);
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			res_s2 <= res_next;
		end
	end

	assign res = res_s2;

endmodule
`default_nettype wire

// ===== src/acs_merge.sv =====
// Merge stage: pick the first current and first voltage lane, register the result
`default_nettype none
module acs_merge (
	input  wire logic                                    clk,
	input  wire logic                                    load,
	input  wire acs_pkg::cfg_t                           cfg,
	input  wire acs_pkg::lane_res_t [acs_pkg::NumPorts-1:0] lanes,
	output logic                                         current_valid,
	output logic                 [acs_pkg::CmdW-1:0]     current_cmd,
	output logic                                         voltage_valid,
	output logic                 [acs_pkg::CmdW-1:0]     voltage_cmd,
	output logic                                         adjust_valid,
	output logic signed          [acs_pkg::AdjW-1:0]     adjust_value
);
	import acs_pkg::*;

	logic                   cur_hit;
	logic                   vol_hit;
	logic [CmdW-1:0]        cur_sel;
	logic [CmdW-1:0]        vol_sel;
	logic signed [AdjW-1:0] adj_sel;

	logic                   cur_v_q;
	logic [CmdW-1:0]        cur_q;
	logic                   vol_v_q;
	logic [CmdW-1:0]        vol_q;
	logic                   adj_v_q;
	logic signed [AdjW-1:0] adj_q;

	always_comb begin
		cur_hit = 1'b0;
		vol_hit = 1'b0;
		cur_sel = '0;
		vol_sel = '0;
		adj_sel = '0;
		for (int p = 0; p < NumPorts; p++) begin
			if (!cur_hit && is_cur_role(cfg.role[p])) begin
				cur_hit = 1'b1;
				cur_sel = lanes[p].cur;
			end
			if (!vol_hit && is_vol_role(cfg.role[p])) begin
				vol_hit = 1'b1;
				vol_sel = lanes[p].vol;
				adj_sel = lanes[p].adj;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_v_q <= cfg.connected && cur_hit;
			cur_q   <= (cfg.connected && cur_hit) ? cur_sel : '0;
			vol_v_q <= cfg.connected && vol_hit && !cfg.unified;
			vol_q   <= (cfg.connected && vol_hit && !cfg.unified) ? vol_sel : '0;
			adj_v_q <= cfg.connected && vol_hit && cfg.unified;
			adj_q   <= (cfg.connected && vol_hit && cfg.unified) ? adj_sel : '0;
		end
	end

	assign current_valid = cur_v_q;
	assign current_cmd   = cur_q;
	assign voltage_valid = vol_v_q;
	assign voltage_cmd   = vol_q;
	assign adjust_valid  = adj_v_q;
	assign adjust_value  = adj_q;

endmodule
`default_nettype wire

// ===== src/analog_command_scaler_core.sv =====
// Top level of the analog command scaler: three scaling lanes and a merge stage
//
// Sample channel: sample_a/b/c with sample_valid, held off by sample_stall.
// Command channel: current, voltage and adjust fields with cmd_valid,
// held off by cmd_stall. One command item leaves for every sample item.
// Configuration: APB registers link_connected, unified_voltage_mode and
// the three port roles at byte addresses 0, 4, 8, 12 and 16; pready is
// always high. Write them only while no item is in flight.
// Path: a sample item passes the lane product stage, the lane
// reciprocal-multiply stage and the merge register; cmd_valid rises when
// the merge register takes the item.
// Throughput: one item per cycle while cmd_stall is low; every stage is a single register.
// A stall on the command side backs the pipeline up one stage at a time;
// sample_stall rises only when all three stages hold items.
// Reset clears the configuration and the stage valid flags; the block
// then reports nothing connected until link_connected is written.
`default_nettype none
module analog_command_scaler_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic        [acs_pkg::PaddrW-1:0]   paddr,
	input  wire logic        [acs_pkg::PdataW-1:0]   pwdata,
	output logic             [acs_pkg::PdataW-1:0]   prdata,
	output logic                                     pready,
	input  wire logic                                sample_valid,
	output logic                                     sample_stall,
	input  wire logic        [acs_pkg::SampleW-1:0]  sample_a,
	input  wire logic        [acs_pkg::SampleW-1:0]  sample_b,
	input  wire logic        [acs_pkg::SampleW-1:0]  sample_c,
	output logic                                     cmd_valid,
	input  wire logic                                cmd_stall,
	output logic                                     current_valid,
	output logic             [acs_pkg::CmdW-1:0]     current_cmd,
	output logic                                     voltage_valid,
	output logic             [acs_pkg::CmdW-1:0]     voltage_cmd,
	output logic                                     adjust_valid,
	output logic signed      [acs_pkg::AdjW-1:0]     adjust_value
);
	import acs_pkg::*;

	cfg_t                                cfg;
	logic [NumPorts-1:0][SampleW-1:0]    samples;
	lane_res_t [NumPorts-1:0]            lanes;

	logic v_s1;
	logic v_s2;
	logic out_v_q;
	logic adv_out;
	logic adv_s2;
	logic adv_s1;

	assign samples[0] = sample_a;
	assign samples[1] = sample_b;
	assign samples[2] = sample_c;

	assign adv_out      = !out_v_q || !cmd_stall;
	assign adv_s2       = !v_s2 || adv_out;
	assign adv_s1       = !v_s1 || adv_s2;
	assign sample_stall = !adv_s1;
	assign cmd_valid    = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= sample_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				out_v_q <= v_s2;
			end
		end
	end

	acs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	for (genvar p = 0; p < NumPorts; p++) begin : g_lane
		acs_lane u_lane (
			.clk     (clk),
			.load_s1 (adv_s1 && sample_valid),
			.load_s2 (adv_s2 && v_s1),
			.sample  (samples[p]),
			.role    (cfg.role[p]),
			.res     (lanes[p])
		);
	end

	acs_merge u_merge (
		.clk           (clk),
		.load          (adv_out && v_s2),
		.cfg           (cfg),
		.lanes         (lanes),
		.current_valid (current_valid),
		.current_cmd   (current_cmd),
		.voltage_valid (voltage_valid),
		.voltage_cmd   (voltage_cmd),
		.adjust_valid  (adjust_valid),
		.adjust_value  (adjust_value)
	);

endmodule
`default_nettype wire

// ===== src/acs_checker.sv =====
// Port-level checker of the analog command scaler and its bind
`default_nettype none
`include "analog_command_scaler_core_assert.svh"
module acs_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               cmd_valid,
	input wire logic                               cmd_stall,
	input wire logic                               current_valid,
	input wire logic        [acs_pkg::CmdW-1:0]    current_cmd,
	input wire logic                               voltage_valid,
	input wire logic        [acs_pkg::CmdW-1:0]    voltage_cmd,
	input wire logic                               adjust_valid,
	input wire logic signed [acs_pkg::AdjW-1:0]    adjust_value
);
	import acs_pkg::*;

	logic                  both_vol;
	logic                  cur_ok;
	logic                  vol_ok;
	logic [2*CmdW-1:0]     cmd_pair;

	assign both_vol = voltage_valid && adjust_valid;
	assign cur_ok   = (current_cmd >= 9'd30) && (current_cmd <= 9'd350);
	assign vol_ok   = (voltage_cmd >= 9'd50) && (voltage_cmd <= 9'd400);
	assign cmd_pair = {current_cmd, voltage_cmd};

	`ACS_NEVER(a_vol_adj_excl, cmd_valid && both_vol, "voltage and adjust both valid")
	`ACS_ASSERT(a_cur_range, cmd_valid && current_valid |-> cur_ok, "current out of range")
	`ACS_ASSERT(a_vol_range, cmd_valid && voltage_valid |-> vol_ok, "voltage out of range")
	`ACS_ASSERT(a_adj_zero, cmd_valid && !adjust_valid |-> adjust_value == 8'sd0, "stray adjust")
	`ACS_ASSERT(a_hold, cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_pair), "item changed")

endmodule

bind analog_command_scaler_core acs_checker u_acs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd_valid),
	.cmd_stall     (cmd_stall),
	.current_valid (current_valid),
	.current_cmd   (current_cmd),
	.voltage_valid (voltage_valid),
	.voltage_cmd   (voltage_cmd),
	.adjust_valid  (adjust_valid),
	.adjust_value  (adjust_value)
);
`default_nettype wire
